/* rtl/core/jls_pkg.sv */
// shared constants, types and helpers for the jacobi solver core
package jls_pkg;
	localparam int Size = 4;
	localparam int IdxW = $clog2(Size);
	localparam int CoefDepth = Size * (Size + 1);
	localparam int CoefAw = $clog2(CoefDepth);
	localparam int MatAw = $clog2(Size * Size);
	localparam logic [7:0] ResetIterations = 8'd20;
	localparam logic signed [63:0] QMax = 64'sd2147483647;
	localparam logic signed [63:0] QMin = -64'sd2147483648;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_DREAD,
		ST_DWAIT,
		ST_NREAD,
		ST_NWAIT,
		ST_DIV,
		ST_DSTORE,
		ST_SWEEP_INIT,
		ST_MREAD,
		ST_MWAIT,
		ST_MUL,
		ST_ACC,
		ST_ROWEND,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic        start;
		logic signed [31:0] num;
		logic signed [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic signed [63:0] quot;
	} div_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > QMax) r = 32'sh7fffffff;
		else if (v < QMin) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction
endpackage

/* rtl/core/jls_div.sv */
// radix-2 restoring divider for (n * 2^16) / d, truncated toward zero
module jls_div (
	input  logic              clk,
	input  logic              arst_n,
	input  jls_pkg::div_req_t req,
	output jls_pkg::div_rsp_t rsp
);
	import jls_pkg::*;

	logic [47:0] dvd_q;
	logic [31:0] dvs_q;
	logic [32:0] rem_q;
	logic [47:0] quo_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic [32:0] shifted;
	logic [63:0] nabs;
	logic [31:0] dabs;

	always_comb begin
		nabs = req.num[31] ? -{{32{req.num[31]}}, req.num} : {{32{1'b0}}, req.num};
		dabs = req.den[31] ? 32'(-req.den) : req.den;
		shifted = {rem_q[31:0], dvd_q[47]};
		trial = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd48;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			dvd_q <= {nabs[31:0], 16'd0};
			dvs_q <= dabs;
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= req.num[31] ^ req.den[31];
		end else if (busy_q) begin
			dvd_q <= {dvd_q[46:0], 1'b0};
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? -$signed({16'd0, quo_q}) : $signed({16'd0, quo_q});
endmodule

/* rtl/core/jacobi_linear_solver_core.sv */
// top level of the jacobi iterative solver core
// usage:
// the input channel takes one word per cycle: row, column, entry_value and
// load_last. a column equal to the system size loads the right-hand side.
// entries outside the system are dropped. the word with load_last starts a
// solve, and the input stalls until every solution word has been taken.
// the solve divides each row by its diagonal on one shared 48-step divider,
// then runs iteration_count sweeps on one shared multiplier.
// the output channel then gives one word per unknown, in index order, with
// zero_pivot set if any diagonal was zero and result_last on the final one.
// a stalled output holds its word and the sequencer waits.
// cfg_we writes iteration_count; the user must do so only while idle, as
// the core does not enforce it. reset sets iteration_count to 20 and
// returns to loading; stored coefficients stay undefined until written.
module jacobi_linear_solver_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  row,
	input  logic [4:0]  column,
	input  logic signed [31:0] entry_value,
	input  logic        load_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  unknown_index,
	output logic signed [31:0] solution_value,
	output logic        zero_pivot,
	output logic        result_last
);
	import jls_pkg::*;

	logic signed [31:0] coef_mem [CoefDepth];
	logic signed [31:0] mat_mem [Size * Size];
	logic signed [31:0] offs_q [Size];
	logic signed [31:0] cur_q [Size];
	logic signed [31:0] prev_q [Size];
	logic signed [31:0] rd_q;
	logic signed [31:0] den_q;
	logic signed [63:0] prod_q;
	logic signed [63:0] acc_q;
	logic [7:0]  iter_cfg_q;
	logic [7:0]  sweep_q;
	logic [IdxW-1:0] i_q;
	logic [IdxW:0]   j_q;
	logic        piv_q;
	logic        ovalid_q;
	state_t      state_q;
	state_t      state_d;
	div_req_t    dreq;
	div_rsp_t    drsp;
	logic        in_ok;
	logic        wr_en;
	logic [CoefAw-1:0] wr_addr;
	logic [CoefAw-1:0] rd_addr;
	logic [MatAw-1:0]  m_addr;
	logic signed [63:0] mprod;

	jls_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign in_ok = in_valid && !in_stall;
	assign in_stall = (state_q != ST_LOAD);
	assign wr_en = in_ok && (row < 4'(Size)) && (column <= 5'(Size));
	assign wr_addr = CoefAw'(row * (Size + 1) + column);
	assign m_addr = MatAw'(i_q * Size + j_q[IdxW-1:0]);
	assign mprod = prod_q >>> 16;

	always_comb begin
		rd_addr = CoefAw'(i_q * (Size + 1) + j_q);
		if (state_q == ST_DREAD) rd_addr = CoefAw'(i_q * (Size + 1) + i_q);
	end

	always_ff @(posedge clk) begin
		if (wr_en) coef_mem[wr_addr] <= entry_value;
		rd_q <= coef_mem[rd_addr];
	end

	always_comb begin
		dreq.start = (state_q == ST_NWAIT) && (j_q[IdxW-1:0] != i_q || j_q == (IdxW+1)'(Size));
		dreq.num = rd_q;
		dreq.den = den_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: if (in_ok && load_last) state_d = ST_DREAD;
			ST_DREAD: state_d = ST_DWAIT;
			ST_DWAIT: state_d = ST_NREAD;
			ST_NREAD: state_d = ST_NWAIT;
			ST_NWAIT: state_d = dreq.start ? ST_DIV : ST_DSTORE;
			ST_DIV: if (drsp.done) state_d = ST_DSTORE;
			ST_DSTORE: begin
				if (j_q == (IdxW+1)'(Size)) begin
					if (i_q == IdxW'(Size - 1)) state_d = ST_SWEEP_INIT;
					else state_d = ST_DREAD;
				end else state_d = ST_NREAD;
			end
			ST_SWEEP_INIT: state_d = (sweep_q == iter_cfg_q) ? ST_OUT : ST_MREAD;
			ST_MREAD: state_d = ST_MWAIT;
			ST_MWAIT: state_d = ST_MUL;
			ST_MUL: state_d = ST_ACC;
			ST_ACC: state_d = (j_q == (IdxW+1)'(Size - 1)) ? ST_ROWEND : ST_MREAD;
			ST_ROWEND: state_d = (i_q == IdxW'(Size - 1)) ? ST_SWEEP_INIT : ST_MREAD;
			ST_OUT: if (ovalid_q && !out_stall && i_q == IdxW'(Size - 1)) state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
	end

	logic signed [31:0] mat_rd;
	logic signed [31:0] prev_rd;

	always_ff @(posedge clk) begin
		if (state_q == ST_DSTORE && j_q != (IdxW+1)'(Size)) begin
			if (den_q == 0 || j_q[IdxW-1:0] == i_q) mat_mem[m_addr] <= '0;
			else mat_mem[m_addr] <= sat32(-drsp.quot);
		end
		mat_rd <= mat_mem[m_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_cfg_q <= ResetIterations;
			piv_q <= 1'b0;
			ovalid_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			sweep_q <= '0;
		end else begin
			if (cfg_we) iter_cfg_q <= cfg_wdata;
			unique case (state_q)
				ST_LOAD: begin
					i_q <= '0;
					j_q <= '0;
					piv_q <= 1'b0;
				end
				ST_DWAIT: begin
					j_q <= '0;
					if (rd_q == 0) piv_q <= 1'b1;
				end
				ST_DSTORE: begin
					if (j_q == (IdxW+1)'(Size)) begin
						i_q <= i_q + 1'b1;
						j_q <= '0;
						sweep_q <= '0;
					end else j_q <= j_q + 1'b1;
				end
				ST_SWEEP_INIT: begin
					i_q <= '0;
					j_q <= '0;
					if (sweep_q != iter_cfg_q) sweep_q <= sweep_q + 1'b1;
				end
				ST_ACC: if (j_q != (IdxW+1)'(Size - 1)) j_q <= j_q + 1'b1;
				ST_ROWEND: begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end
				ST_OUT: begin
					if (!ovalid_q) ovalid_q <= 1'b1;
					else if (!out_stall) begin
						if (i_q == IdxW'(Size - 1)) ovalid_q <= 1'b0;
						i_q <= i_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DWAIT) den_q <= rd_q;
		if (state_q == ST_DSTORE && j_q == (IdxW+1)'(Size))
			offs_q[i_q] <= (den_q == 0) ? 32'sd0 : sat32(drsp.quot);
		if (state_q == ST_DSTORE && j_q == (IdxW+1)'(Size) && i_q == IdxW'(Size - 1))
			for (int k = 0; k < Size; k++) cur_q[k] <= '0;
		if (state_q == ST_SWEEP_INIT)
			for (int k = 0; k < Size; k++) prev_q[k] <= cur_q[k];
		if (state_q == ST_MREAD && j_q == '0) acc_q <= 64'(offs_q[i_q]);
		if (state_q == ST_MWAIT) prev_rd <= prev_q[j_q[IdxW-1:0]];
		if (state_q == ST_MUL) prod_q <= 64'(mat_rd) * 64'(prev_rd);
		if (state_q == ST_ACC)
			acc_q <= acc_q + 64'(sat32((prod_q < 0) ? -((-prod_q) >>> 16) : mprod));
		if (state_q == ST_ROWEND) cur_q[i_q] <= sat32(acc_q);
	end

	assign out_valid = ovalid_q;
	assign unknown_index = 4'(i_q);
	assign solution_value = cur_q[i_q];
	assign zero_pivot = piv_q;
	assign result_last = (i_q == IdxW'(Size - 1));
endmodule
